FILE: sv/bpd_pkg.sv
// Shared types and constants of the biosignal packet deframer.
package bpd_pkg;

  localparam int unsigned EegChannelsDef = 8;
  localparam int unsigned AccelAxesDef   = 3;

  localparam logic [7:0] HEADER_BYTE = 8'hA0;
  localparam logic [7:0] FOOTER_BYTE = 8'hC0;

  localparam int unsigned KindW  = 3;
  localparam int unsigned IndexW = 3;
  localparam int unsigned ValueW = 24;
  localparam int unsigned RegIdxW = 8;

  localparam logic [KindW-1:0] KIND_SAMPLE      = 3'd0;
  localparam logic [KindW-1:0] KIND_EEG         = 3'd1;
  localparam logic [KindW-1:0] KIND_ACCEL       = 3'd2;
  localparam logic [KindW-1:0] KIND_OK          = 3'd3;
  localparam logic [KindW-1:0] KIND_DROP_SAMPLE = 3'd4;
  localparam logic [KindW-1:0] KIND_DROP_FOOTER = 3'd5;

  localparam logic [RegIdxW-1:0] REG_UV_SCALE   = 8'd0;
  localparam logic [RegIdxW-1:0] REG_JUMP_LIMIT = 8'd1;

  localparam logic [31:0] UV_SCALE_RESET   = 32'd375000;
  localparam logic [7:0]  JUMP_LIMIT_RESET = 8'd20;

  localparam logic [7:0] UG_PER_ACCEL_COUNT = 8'd125;

  // Raw field handed from the parser to the scaler.
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] raw;
    logic              last;
  } item_t;

endpackage

FILE: sv/bpd_if.sv
// Handshake channels of the biosignal packet deframer.
interface bpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bpd_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         field_kind;
  logic [2:0]         field_index;
  logic signed [23:0] field_value;
  logic               packet_last;
  modport source (output valid, output field_kind, output field_index,
                  output field_value, output packet_last, input ready);
  modport sink (input valid, input field_kind, input field_index,
                input field_value, input packet_last, output ready);
endinterface

interface bpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/biosignal_packet_deframer.sv
// Biosignal packet deframer top level: config registers, parser and scaler.
// Throughput: one rx byte per cycle, sustained, under no output back-pressure.
// A word reaches res_o through the parse register and then the scaled result
// register, with the multiply in between.
// Reset: parser hunts for a header, last sample number clears to zero,
// scale and jump-limit registers take their defaults; no clearing pass.
module biosignal_packet_deframer #(
  parameter int unsigned EEG_CHANNELS = bpd_pkg::EegChannelsDef,
  parameter int unsigned ACCEL_AXES   = bpd_pkg::AccelAxesDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  bpd_rx_if.sink      rx_i,
  bpd_res_if.source   res_o,
  bpd_cfg_if.sink     cfg_i
);
  import bpd_pkg::*;

  logic [31:0]    uv_scale_q;
  logic [7:0]     jump_limit_q;
  logic           cfg_fire;
  logic           item_valid;
  logic           item_ready;
  item_t          item;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_scale_q   <= UV_SCALE_RESET;
      jump_limit_q <= JUMP_LIMIT_RESET;
    end else if (cfg_fire) begin
      if (cfg_i.index == REG_UV_SCALE) begin
        uv_scale_q <= cfg_i.data;
      end else if (cfg_i.index == REG_JUMP_LIMIT) begin
        jump_limit_q <= cfg_i.data[7:0];
      end
    end
  end

  bpd_parser #(
    .EEG_CHANNELS (EEG_CHANNELS),
    .ACCEL_AXES   (ACCEL_AXES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_i.valid),
    .rx_ready_o   (rx_i.ready),
    .rx_byte_i    (rx_i.rx_byte),
    .jump_limit_i (jump_limit_q),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  bpd_scaler u_scaler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .uv_scale_i    (uv_scale_q),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .field_kind_o  (res_o.field_kind),
    .field_index_o (res_o.field_index),
    .field_value_o (res_o.field_value),
    .packet_last_o (res_o.packet_last)
  );

endmodule

FILE: sv/bpd_parser.sv
// Byte-level packet parser; registers one raw field per completed word and a status item at each packet end.
module bpd_parser #(
  parameter int unsigned EEG_CHANNELS = bpd_pkg::EegChannelsDef,
  parameter int unsigned ACCEL_AXES   = bpd_pkg::AccelAxesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_ready_o,
  input  logic [7:0]     rx_byte_i,
  input  logic [7:0]     jump_limit_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output bpd_pkg::item_t item_o
);
  import bpd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SAMPLE,
    PH_EEG,
    PH_ACCEL,
    PH_FOOTER
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [1:0]         byte_cnt_q, byte_cnt_d;
  logic [IndexW-1:0]  field_cnt_q, field_cnt_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [7:0]         last_sn_q, last_sn_d;
  logic               valid_q;
  item_t              item_q, item_d;
  logic               emit;
  logic               in_fire;
  logic [ValueW-1:0]  acc_next;
  logic signed [9:0]  sn_diff;
  logic               sn_drop;

  assign rx_ready_o   = !valid_q || item_ready_i;
  assign in_fire      = rx_valid_i && rx_ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  assign acc_next = {acc_q[ValueW-9:0], rx_byte_i};
  assign sn_diff  = $signed({2'b00, rx_byte_i}) - $signed({2'b00, last_sn_q});
  assign sn_drop  = (rx_byte_i == last_sn_q) || (sn_diff > $signed({2'b00, jump_limit_i}));

  always_comb begin
    phase_d     = phase_q;
    byte_cnt_d  = byte_cnt_q;
    field_cnt_d = field_cnt_q;
    acc_d       = acc_q;
    last_sn_d   = last_sn_q;
    emit        = 1'b0;
    item_d      = '{kind: KIND_SAMPLE, index: '0, raw: '0, last: 1'b0};
    case (phase_q)
      PH_SAMPLE: begin
        emit = 1'b1;
        if (sn_drop) begin
          phase_d     = PH_HUNT;
          item_d.kind = KIND_DROP_SAMPLE;
          item_d.last = 1'b1;
        end else begin
          last_sn_d  = rx_byte_i;
          phase_d    = PH_EEG;
          item_d.raw = {16'h0000, rx_byte_i};
        end
      end
      PH_EEG: begin
        if (byte_cnt_q == 2'd2) begin
          emit         = 1'b1;
          item_d.kind  = KIND_EEG;
          item_d.index = field_cnt_q;
          item_d.raw   = acc_next;
          byte_cnt_d   = '0;
          acc_d        = '0;
          if (field_cnt_q == IndexW'(EEG_CHANNELS - 1)) begin
            field_cnt_d = '0;
            phase_d     = PH_ACCEL;
          end else begin
            field_cnt_d = field_cnt_q + 1'b1;
          end
        end else begin
          byte_cnt_d = byte_cnt_q + 1'b1;
          acc_d      = acc_next;
        end
      end
      PH_ACCEL: begin
        if (byte_cnt_q == 2'd1) begin
          emit         = 1'b1;
          item_d.kind  = KIND_ACCEL;
          item_d.index = field_cnt_q;
          item_d.raw   = {8'h00, acc_next[15:0]};
          byte_cnt_d   = '0;
          acc_d        = '0;
          if (field_cnt_q == IndexW'(ACCEL_AXES - 1)) begin
            field_cnt_d = '0;
            phase_d     = PH_FOOTER;
          end else begin
            field_cnt_d = field_cnt_q + 1'b1;
          end
        end else begin
          byte_cnt_d = byte_cnt_q + 1'b1;
          acc_d      = acc_next;
        end
      end
      PH_FOOTER: begin
        emit        = 1'b1;
        phase_d     = PH_HUNT;
        item_d.last = 1'b1;
        item_d.kind = (rx_byte_i == FOOTER_BYTE) ? KIND_OK : KIND_DROP_FOOTER;
      end
      default: begin
        if (rx_byte_i == HEADER_BYTE) begin
          byte_cnt_d  = '0;
          field_cnt_d = '0;
          acc_d       = '0;
          phase_d     = PH_SAMPLE;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      byte_cnt_q  <= '0;
      field_cnt_q <= '0;
      acc_q       <= '0;
      last_sn_q   <= '0;
      valid_q     <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      byte_cnt_q  <= byte_cnt_d;
      field_cnt_q <= field_cnt_d;
      acc_q       <= acc_d;
      last_sn_q   <= last_sn_d;
      valid_q     <= emit;
    end else if (item_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_d;
    end
  end

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && item_q.last |->
      (item_q.kind == KIND_OK) || (item_q.kind == KIND_DROP_SAMPLE) ||
      (item_q.kind == KIND_DROP_FOOTER))
    else $error("packet_last on a data field");

  a_counters_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_EEG) && (phase_q != PH_ACCEL) |->
      (byte_cnt_q == '0) && (field_cnt_q == '0))
    else $error("field counters not cleared outside data phases");

  a_footer_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (phase_q == PH_FOOTER) |=> (phase_q == PH_HUNT) && valid_q && item_q.last)
    else $error("footer did not close the packet");

endmodule

FILE: sv/bpd_scaler.sv
// Field scaling to microvolts and micro-g, with the result register.
module bpd_scaler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  bpd_pkg::item_t item_i,
  input  logic [31:0]    uv_scale_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     field_kind_o,
  output logic [2:0]     field_index_o,
  output logic [23:0]    field_value_o,
  output logic           packet_last_o
);
  import bpd_pkg::*;

  logic               valid_q;
  logic [KindW-1:0]   kind_q;
  logic [IndexW-1:0]  index_q;
  logic [ValueW-1:0]  value_q, value_d;
  logic               last_q;
  logic               load;
  logic               neg;
  logic [23:0]        mag;
  logic [55:0]        prod;
  logic [31:0]        prod_sh;
  logic [23:0]        eeg_val;
  logic [23:0]        neg_clamp;
  logic signed [23:0] accel_ext;
  logic signed [23:0] accel_val;

  assign item_ready_o = !valid_q || out_ready_i;
  assign load         = item_valid_i && item_ready_o;

  assign neg       = item_i.raw[23];
  assign mag       = neg ? (24'(25'h1000000 - {1'b0, item_i.raw})) : {1'b0, item_i.raw[22:0]};
  assign prod      = 56'(mag) * 56'(uv_scale_i);
  assign prod_sh   = prod[55:24];
  assign neg_clamp = (prod_sh > 32'h0080_0000) ? 24'h80_0000 : prod_sh[23:0];

  always_comb begin
    if (neg) begin
      eeg_val = 24'(-neg_clamp);
    end else if (prod_sh > 32'h007F_FFFF) begin
      eeg_val = 24'h7F_FFFF;
    end else begin
      eeg_val = prod_sh[23:0];
    end
  end

  assign accel_ext = {{8{item_i.raw[15]}}, item_i.raw[15:0]};
  assign accel_val = 24'(accel_ext * $signed({16'h0000, UG_PER_ACCEL_COUNT}));

  always_comb begin
    case (item_i.kind)
      KIND_EEG:   value_d = eeg_val;
      KIND_ACCEL: value_d = accel_val;
      default:    value_d = item_i.raw;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_ready_o) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= item_i.kind;
      index_q <= item_i.index;
      value_q <= value_d;
      last_q  <= item_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign field_kind_o  = kind_q;
  assign field_index_o = index_q;
  assign field_value_o = value_q;
  assign packet_last_o = last_q;

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ((kind_q == KIND_OK) || (kind_q == KIND_DROP_SAMPLE) ||
                (kind_q == KIND_DROP_FOOTER)) |-> (value_q == '0))
    else $error("status word carries a value");

  a_sample_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (kind_q == KIND_SAMPLE) |-> (value_q[23:8] == '0) && (index_q == '0))
    else $error("sample number word out of range");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_q)
    else $error("loaded word not presented");

endmodule

FILE: sim/biosignal_packet_deframer_tb.sv
// Self-checking testbench for the biosignal packet deframer: directed and random byte streams.
module biosignal_packet_deframer_tb;
  import bpd_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_CAP    = 40;

  typedef enum logic [2:0] {P_HUNT, P_SAMPLE, P_EEG, P_ACCEL, P_FOOTER} parse_phase_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic              last;
  } field_rec_t;

  typedef struct packed {
    parse_phase_e phase;
    logic [1:0]   byte_cnt;
    logic [3:0]   field_cnt;
    logic [23:0]  acc;
    logic [7:0]   last_sample;
    logic [31:0]  uv_scale;
    logic [7:0]   jump_limit;
  } parser_t;

  logic clk_i;
  logic rst_ni;

  bpd_rx_if  rx_if ();
  bpd_res_if res_if ();
  bpd_cfg_if cfg_if ();

  biosignal_packet_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  logic [7:0]  tx_bytes[$];
  field_rec_t  pending_fields[$];
  parser_t     chk_st;
  parser_t     sched_st;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned counted_items;
  int unsigned bytes_sent;
  int unsigned fields_checked;
  int unsigned reg_writes;
  int unsigned kind_seen[6];
  int unsigned stall_cycles;

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic parser_t parser_after_reset();
    parser_t st;
    st = '0;
    st.phase = P_HUNT;
    st.uv_scale = UV_SCALE_RESET;
    st.jump_limit = JUMP_LIMIT_RESET;
    return st;
  endfunction

  function automatic logic [23:0] eeg_microvolts(logic [23:0] raw, logic [31:0] scale);
    logic [24:0] mag;
    logic [63:0] prod;
    mag = raw[23] ? (25'h100_0000 - {1'b0, raw}) : {2'b00, raw[22:0]};
    prod = ({39'd0, mag} * {32'd0, scale}) >> 24;
    if (raw[23]) begin
      if (prod > 64'd8388608) prod = 64'd8388608;
      return 24'(-prod);
    end
    if (prod > 64'd8388607) prod = 64'd8388607;
    return prod[23:0];
  endfunction

  function automatic logic [23:0] accel_micro_g(logic [15:0] raw);
    int count;
    count = int'($signed(raw));
    return 24'(count * int'(UG_PER_ACCEL_COUNT));
  endfunction

  function automatic void parse_byte(inout parser_t st, input logic [7:0] b,
                                     output field_rec_t rec, output bit produced);
    int diff;
    rec = '0;
    produced = 1'b0;
    case (st.phase)
      P_SAMPLE: begin
        diff = int'(b) - int'(st.last_sample);
        produced = 1'b1;
        if (b == st.last_sample || diff > int'(st.jump_limit)) begin
          st.phase = P_HUNT;
          rec = '{KIND_DROP_SAMPLE, 3'd0, 24'd0, 1'b1};
        end else begin
          st.last_sample = b;
          st.phase = P_EEG;
          rec = '{KIND_SAMPLE, 3'd0, {16'd0, b}, 1'b0};
        end
      end
      P_EEG: begin
        st.acc = {st.acc[15:0], b};
        st.byte_cnt = st.byte_cnt + 2'd1;
        if (st.byte_cnt == 2'd3) begin
          produced = 1'b1;
          rec = '{KIND_EEG, st.field_cnt[2:0], eeg_microvolts(st.acc, st.uv_scale), 1'b0};
          st.byte_cnt = '0;
          st.acc = '0;
          if (st.field_cnt + 1 >= EegChannelsDef) begin
            st.field_cnt = '0;
            st.phase = P_ACCEL;
          end else begin
            st.field_cnt = st.field_cnt + 4'd1;
          end
        end
      end
      P_ACCEL: begin
        st.acc = {st.acc[15:0], b};
        st.byte_cnt = st.byte_cnt + 2'd1;
        if (st.byte_cnt == 2'd2) begin
          produced = 1'b1;
          rec = '{KIND_ACCEL, st.field_cnt[2:0], accel_micro_g(st.acc[15:0]), 1'b0};
          st.byte_cnt = '0;
          st.acc = '0;
          if (st.field_cnt + 1 >= AccelAxesDef) begin
            st.field_cnt = '0;
            st.phase = P_FOOTER;
          end else begin
            st.field_cnt = st.field_cnt + 4'd1;
          end
        end
      end
      P_FOOTER: begin
        produced = 1'b1;
        st.phase = P_HUNT;
        if (b == FOOTER_BYTE) rec = '{KIND_OK, 3'd0, 24'd0, 1'b1};
        else rec = '{KIND_DROP_FOOTER, 3'd0, 24'd0, 1'b1};
      end
      default: begin
        if (b == HEADER_BYTE) begin
          st.byte_cnt = '0;
          st.field_cnt = '0;
          st.acc = '0;
          st.phase = P_SAMPLE;
        end else begin
          st.phase = P_HUNT;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Driver: hold a byte until accepted, then advance or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= tx_bytes.pop_front();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check returned words first, then predict from accepted bytes.
  always @(posedge clk_i) begin
    field_rec_t got;
    field_rec_t want;
    field_rec_t fresh;
    bit produced;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.field_kind, res_if.field_index, res_if.field_value,
                res_if.packet_last};
        fields_checked++;
        if (got.kind < 6) kind_seen[got.kind]++;
        if (pending_fields.size() == 0) begin
          report_mismatch("unexpected word, kind", got.kind, 0);
        end else begin
          want = pending_fields.pop_front();
          if (got.kind !== want.kind) report_mismatch("field_kind", got.kind, want.kind);
          if (got.index !== want.index)
            report_mismatch("field_index", got.index, want.index);
          if (got.value !== want.value)
            report_mismatch("field_value", got.value, want.value);
          if (got.last !== want.last)
            report_mismatch("packet_last", got.last, want.last);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_UV_SCALE:   chk_st.uv_scale = cfg_if.data;
          REG_JUMP_LIMIT: chk_st.jump_limit = cfg_if.data[7:0];
          default: ;
        endcase
      end
      if (rx_if.valid && rx_if.ready) begin
        bytes_sent++;
        parse_byte(chk_st, rx_if.rx_byte, fresh, produced);
        if (produced) pending_fields.push_back(fresh);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               STALL_LIMIT, pending_fields.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    field_rec_t unused;
    bit produced;
    if (sched_st.phase != P_HUNT || b == HEADER_BYTE) counted_items++;
    parse_byte(sched_st, b, unused, produced);
    tx_bytes.push_back(b);
  endfunction

  function automatic void push_count(logic [23:0] value, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) push_byte(value[8*i +: 8]);
  endfunction

  function automatic logic [23:0] pick_count(int unsigned nbits);
    logic [23:0] top;
    logic [23:0] mask;
    top = 24'd1 << (nbits - 1);
    mask = (top << 1) - 24'd1;
    case ($urandom_range(7))
      0: return top - 24'd1;
      1: return top;
      2: return mask;
      3: return 24'd0;
      4: return 24'(int'($urandom_range(512)) - 256) & mask;
      default: return 24'($urandom) & mask;
    endcase
  endfunction

  function automatic logic [7:0] pick_sample(bit good);
    int last;
    int lim;
    int hi;
    last = int'(sched_st.last_sample);
    lim = int'(sched_st.jump_limit);
    hi = (last + lim > 255) ? 255 : last + lim;
    if (good) begin
      if (hi > last && (last == 0 || $urandom_range(9) < 7))
        return 8'(last + int'($urandom_range(1, hi - last)));
      if (last > 0) begin
        if ($urandom_range(1)) return 8'($urandom_range(last - 1));
        return 8'(last - int'($urandom_range(1, (last < 4) ? last : 4)));
      end
    end
    if (last + lim + 1 <= 255 && $urandom_range(1))
      return 8'($urandom_range(last + lim + 1, 255));
    return 8'(last);
  endfunction

  function automatic void push_packet(bit good_sample, bit good_footer);
    logic [7:0] tail;
    push_byte(HEADER_BYTE);
    push_byte(pick_sample(good_sample));
    if (sched_st.phase != P_EEG) return;
    for (int ch = 0; ch < EegChannelsDef; ch++) push_count(pick_count(24), 3);
    for (int ax = 0; ax < AccelAxesDef; ax++) push_count(pick_count(16), 2);
    if (good_footer) begin
      push_byte(FOOTER_BYTE);
    end else begin
      tail = $urandom_range(3) == 0 ? HEADER_BYTE : 8'($urandom);
      if (tail == FOOTER_BYTE) tail = ~tail;
      push_byte(tail);
    end
  endfunction

  // Bring the parser back to header hunt so that register writes land between packets.
  function automatic void close_packet();
    while (sched_st.phase != P_HUNT)
      push_byte(sched_st.phase == P_SAMPLE ? sched_st.last_sample : 8'($urandom));
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 53; end
      IDLE_BOTH: begin send_idle_pct = 36; recv_stall_pct = 36; end
      default:   begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || rx_if.valid) @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] scale, input logic [7:0] limit,
                           input idle_mode_e mode, input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    write_reg(REG_UV_SCALE, scale);
    write_reg(REG_JUMP_LIMIT, limit);
    sched_st.uv_scale = scale;
    sched_st.jump_limit = limit;
    set_idle(mode);
    start = counted_items;
    while (counted_items - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_packet(1'b1, $urandom_range(9) != 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else if (pick < 90) begin
        push_packet(1'b0, 1'b1);
      end else begin
        push_byte(HEADER_BYTE);
        push_byte(pick_sample(1'b1));
        repeat ($urandom_range(30)) push_byte(8'($urandom));
      end
    end
    close_packet();
    wait_idle();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    chk_st = parser_after_reset();
    sched_st = parser_after_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Noise while hunting, zero first sample, jump past the limit, then a full
    // packet with extreme counts and a header byte inside, a repeated sample,
    // a backward step with a header byte as bad footer, and a byte after it.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(FOOTER_BYTE);
    push_byte(HEADER_BYTE);
    push_byte(8'd0);
    push_byte(HEADER_BYTE);
    push_byte(8'd21);
    push_byte(HEADER_BYTE);
    push_byte(8'd20);
    push_count(24'h7FFFFF, 3);
    push_count(24'h800000, 3);
    push_count(24'h000000, 3);
    push_count(24'hFFFFFF, 3);
    push_count(24'hA0A0A0, 3);
    push_count(24'h000001, 3);
    push_count(24'h555555, 3);
    push_count(24'hAAAAAA, 3);
    push_count(24'h7FFF, 2);
    push_count(24'h8000, 2);
    push_count(24'hFFFF, 2);
    push_byte(FOOTER_BYTE);
    push_byte(HEADER_BYTE);
    push_byte(8'd20);
    push_byte(HEADER_BYTE);
    push_byte(8'd5);
    for (int ch = 0; ch < EegChannelsDef; ch++) push_count(pick_count(24), 3);
    push_count(24'h0001, 2);
    push_count(24'h0000, 2);
    push_count(24'h5A5A, 2);
    push_byte(HEADER_BYTE);
    push_byte(8'h11);
    wait_idle();

    run_phase(32'hFFFF_FFFF, 8'd255, IDLE_SEND, 165);
    run_phase(32'h0000_0000, 8'd0, IDLE_RECV, 165);
    run_phase(32'h0100_0000, 8'd1, IDLE_BOTH, 165);
    run_phase(32'($urandom), 8'($urandom), IDLE_NONE, 165);
    run_phase(32'($urandom), 8'($urandom_range(1, 254)), IDLE_SEND, 165);
    run_phase(UV_SCALE_RESET, JUMP_LIMIT_RESET, IDLE_RECV, 165);

    $display("run: %0d bytes in, %0d words checked, %0d register writes",
             bytes_sent, fields_checked, reg_writes);
    $display("words by kind: sample %0d eeg %0d accel %0d ok %0d bad-sample %0d bad-footer %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
